// File: rtl/temperature_alarm_qualifier_macros.svh
// Assertion macros used by the checker file.
`ifndef TEMPERATURE_ALARM_QUALIFIER_MACROS_SVH
`define TEMPERATURE_ALARM_QUALIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TAQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("taq check failed");

// Consequent must hold in the cycle after the antecedent.
`define TAQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("taq check failed");

`endif

// File: rtl/taq_pkg.sv
package taq_pkg;

    localparam int TEMP_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int LIMIT_W    = 16;
    localparam int MODE_W     = 2;
    localparam int PERIOD_W   = 16;
    localparam int DELAY_W    = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALARM_MODE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ALARM_DELAY   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_SINGLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CUMULATIVE = 2'd1;

    localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RST    = 16'sd800;
    localparam logic signed [LIMIT_W-1:0] LOW_LIMIT_RST     = -16'sd320;
    localparam logic [MODE_W-1:0]         ALARM_MODE_RST    = MODE_SINGLE;
    localparam logic [PERIOD_W-1:0]       SAMPLE_PERIOD_RST = 16'd10;
    localparam logic [DELAY_W-1:0]        ALARM_DELAY_RST   = 24'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_RUN,
        ST_JUDGE,
        ST_DONE
    } taq_state_t;

endpackage

// File: rtl/temperature_alarm_qualifier.sv
// m_tvalid rises after a beat is accepted, once the sample has passed ST_UPDATE, ST_RUN, ST_JUDGE
// and ST_DONE, if the output register is free. s_tready stays low until the result is loaded
// into the output register, so a new sample waits for the bit-serial divider that forms the
// window mean one quotient bit per cycle.
// Reset (rst_n low, asynchronous) restores the register defaults, closes the window,
// clears the sticky alarm and empties the output register.
module temperature_alarm_qualifier #(
    parameter int TEMP_WIDTH  = taq_pkg::TEMP_WIDTH_DEF,
    parameter int COUNT_WIDTH = taq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [taq_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [taq_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata: temperature
    input  logic [((TEMP_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata: alarm, window_count, window_mean
    output logic [((TEMP_WIDTH+COUNT_WIDTH+8)/8)*8-1:0] m_tdata
);
    import taq_pkg::*;

    localparam int SW  = TEMP_WIDTH + COUNT_WIDTH + 1;
    localparam int PW  = (COUNT_WIDTH + PERIOD_W > DELAY_W) ? COUNT_WIDTH + PERIOD_W : DELAY_W;
    localparam int LW  = (TEMP_WIDTH > LIMIT_W) ? TEMP_WIDTH : LIMIT_W;
    localparam int BCW = $clog2(SW);
    localparam int DW  = ((TEMP_WIDTH + COUNT_WIDTH + 8) / 8) * 8;

    taq_state_t state_reg, state_next;

    logic signed [LIMIT_W-1:0]  high_reg, low_reg;
    logic [MODE_W-1:0]          mode_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [DELAY_W-1:0]         delay_reg;

    logic [COUNT_WIDTH-1:0]     count_reg, count_next;
    logic signed [SW-1:0]       sum_reg, sum_next;
    logic                       alarm_reg;
    logic                       judge_reg, judge_next;

    logic signed [TEMP_WIDTH-1:0] t_reg;
    logic                       neg_reg;
    logic [SW-1:0]              dvd_reg;
    logic [COUNT_WIDTH-1:0]     rem_reg;
    logic [PW-1:0]              mcand_reg, prod_reg;
    logic [COUNT_WIDTH-1:0]     mplier_reg;
    logic [BCW-1:0]             bit_cnt_reg;
    logic signed [TEMP_WIDTH-1:0] mean_reg;

    logic                       out_valid_reg;
    logic                       out_alarm_reg;
    logic [COUNT_WIDTH-1:0]     out_count_reg;
    logic signed [TEMP_WIDTH-1:0] out_mean_reg;

    logic                       ld_out;
    logic signed [LW-1:0]       high_ext, low_ext, t_ext, mean_ext;
    logic                       t_oor, mean_oor, window_long;
    logic [COUNT_WIDTH:0]       rem_sh;
    logic                       q_bit;
    logic [SW-1:0]              q_signed, sum_mag;
    logic signed [TEMP_WIDTH-1:0] mean_val;

    assign high_ext = LW'(high_reg);
    assign low_ext  = LW'(low_reg);
    assign t_ext    = LW'(t_reg);
    assign t_oor    = (t_ext > high_ext) || (t_ext < low_ext);

    // Window update on the captured sample (cumulative mode only).
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        judge_next = 1'b0;
        if (mode_reg == MODE_CUMULATIVE)
        begin
            if (count_reg == '0)
            begin
                if (t_oor)
                begin
                    count_next = COUNT_WIDTH'(1);
                    sum_next   = SW'(t_reg);
                end
            end
            else
            begin
                if (count_reg != '1)
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                    sum_next   = sum_reg + SW'(t_reg);
                end
                judge_next = 1'b1;
            end
        end
    end

    assign sum_mag = sum_next[SW-1] ? (~sum_next + SW'(1)) : sum_next;

    // One restoring-division step per cycle in ST_RUN on the magnitude of the sum.
    assign rem_sh = {rem_reg, dvd_reg[SW-1]};
    assign q_bit  = (rem_sh >= {1'b0, count_reg});

    assign q_signed    = neg_reg ? (~dvd_reg + SW'(1)) : dvd_reg;
    assign mean_val    = q_signed[TEMP_WIDTH-1:0];
    assign mean_ext    = LW'(mean_val);
    assign mean_oor    = (mean_ext > high_ext) || (mean_ext < low_ext);
    assign window_long = prod_reg > PW'(delay_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RUN;
            ST_RUN:    if (bit_cnt_reg == BCW'(SW - 1)) state_next = ST_JUDGE;
            ST_JUDGE:  state_next = ST_DONE;
            ST_DONE:   if (ld_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        ld_out   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'({out_mean_reg, out_count_reg, out_alarm_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            high_reg      <= HIGH_LIMIT_RST;
            low_reg       <= LOW_LIMIT_RST;
            mode_reg      <= ALARM_MODE_RST;
            period_reg    <= SAMPLE_PERIOD_RST;
            delay_reg     <= ALARM_DELAY_RST;
            count_reg     <= '0;
            sum_reg       <= '0;
            alarm_reg     <= 1'b0;
            judge_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_HIGH_LIMIT:    high_reg   <= cfg_data[LIMIT_W-1:0];
                    REG_LOW_LIMIT:     low_reg    <= cfg_data[LIMIT_W-1:0];
                    REG_ALARM_MODE:    mode_reg   <= cfg_data[MODE_W-1:0];
                    REG_SAMPLE_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_ALARM_DELAY:   delay_reg  <= cfg_data[DELAY_W-1:0];
                    default:           ;
                endcase
            end

            if (state_reg == ST_UPDATE)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                judge_reg <= judge_next;
                if (mode_reg == MODE_SINGLE && t_oor)
                    alarm_reg <= 1'b1;
            end

            // A long enough window is judged on its mean: out of range alarms, else it closes.
            if (state_reg == ST_JUDGE && judge_reg && window_long)
            begin
                if (mean_oor)
                    alarm_reg <= 1'b1;
                else
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                end
            end

            if (ld_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            t_reg <= s_tdata[TEMP_WIDTH-1:0];

        unique case (state_reg)
            ST_UPDATE:
            begin
                neg_reg     <= sum_next[SW-1];
                dvd_reg     <= sum_mag;
                rem_reg     <= '0;
                mcand_reg   <= PW'(period_reg);
                mplier_reg  <= count_next;
                prod_reg    <= '0;
                bit_cnt_reg <= '0;
            end
            ST_RUN:
            begin
                rem_reg     <= q_bit ? COUNT_WIDTH'(rem_sh - {1'b0, count_reg})
                                     : rem_sh[COUNT_WIDTH-1:0];
                dvd_reg     <= {dvd_reg[SW-2:0], q_bit};
                if (mplier_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg   <= {mcand_reg[PW-2:0], 1'b0};
                mplier_reg  <= {1'b0, mplier_reg[COUNT_WIDTH-1:1]};
                bit_cnt_reg <= bit_cnt_reg + BCW'(1);
            end
            ST_JUDGE:
            begin
                if (count_reg == '0 || (judge_reg && window_long && !mean_oor))
                    mean_reg <= '0;
                else
                    mean_reg <= mean_val;
            end
            default: ;
        endcase

        if (ld_out)
        begin
            out_alarm_reg <= alarm_reg;
            out_count_reg <= count_reg;
            out_mean_reg  <= mean_reg;
        end
    end

endmodule

// File: rtl/taq_checker.sv
`include "temperature_alarm_qualifier_macros.svh"

module taq_checker #(
    parameter int TEMP_WIDTH  = taq_pkg::TEMP_WIDTH_DEF,
    parameter int COUNT_WIDTH = taq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    input  logic                                        s_tready,
    input  logic                                        m_tvalid,
    input  logic                                        m_tready,
    input  logic [((TEMP_WIDTH+COUNT_WIDTH+8)/8)*8-1:0] m_tdata
);
    import taq_pkg::*;

    logic                         seen_alarm_reg;
    logic [COUNT_WIDTH-1:0]       beat_count;
    logic [TEMP_WIDTH-1:0]        beat_mean;

    assign beat_count = m_tdata[COUNT_WIDTH:1];
    assign beat_mean  = m_tdata[TEMP_WIDTH+COUNT_WIDTH:COUNT_WIDTH+1];

    // Remembers that an alarm has already left the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_alarm_reg <= 1'b0;
        else if (m_tvalid && m_tready && m_tdata[0])
            seen_alarm_reg <= 1'b1;
    end

    `TAQ_ASSERT_NEXT(a_one_sample_at_a_time, s_tvalid && s_tready, !s_tready)
    `TAQ_ASSERT_NEXT(a_stalled_beat_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TAQ_ASSERT_NOW(a_closed_window_zero_mean, m_tvalid && beat_count == '0, beat_mean == '0)
    `TAQ_ASSERT_NOW(a_alarm_sticky, m_tvalid && seen_alarm_reg, m_tdata[0])

endmodule

bind temperature_alarm_qualifier taq_checker #(
    .TEMP_WIDTH  (TEMP_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
) u_taq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
